@@ sv/gdad_pkg.sv @@
// Shared types, constants and calendar functions for the date-plus-days block.
package gdad_pkg;

    localparam int DAYS_WIDTH_DEF = 16;
    localparam int YEAR_WIDTH_DEF = 16;

    // Status codes of a result word
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [3:0] M_JAN = 4'd1;
    localparam logic [3:0] M_FEB = 4'd2;
    localparam logic [3:0] M_MAR = 4'd3;
    localparam logic [3:0] M_APR = 4'd4;
    localparam logic [3:0] M_MAY = 4'd5;
    localparam logic [3:0] M_JUN = 4'd6;
    localparam logic [3:0] M_JUL = 4'd7;
    localparam logic [3:0] M_AUG = 4'd8;
    localparam logic [3:0] M_SEP = 4'd9;
    localparam logic [3:0] M_OCT = 4'd10;
    localparam logic [3:0] M_NOV = 4'd11;
    localparam logic [3:0] M_DEC = 4'd12;

    localparam logic [4:0] DAY_LAST = 5'd31;

    // Year modulo the 400-year cycle
    localparam logic [9:0] CYCLE_YEARS = 10'd400;
    localparam logic [8:0] CYCLE_LAST  = 9'd399;
    localparam logic [8:0] CENT_1      = 9'd100;
    localparam logic [8:0] CENT_2      = 9'd200;
    localparam logic [8:0] CENT_3      = 9'd300;

    typedef struct packed {
        logic [15:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [15:0] days_to_add;
    } t_req;

    typedef struct packed {
        logic [15:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic [1:0]  status;
    } t_result;

    // Top level to core
    typedef struct packed {
        logic start;
        logic take;
    } t_ctl;

    // Core to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_sts;

    // Leap test from the year's remainder in the 400-year cycle
    function automatic logic is_leap(input logic [8:0] r400);
        logic century;
        century = (r400 == CENT_1) || (r400 == CENT_2) || (r400 == CENT_3);
        return (r400[1:0] == 2'd0) && !century;
    endfunction

    // Month length; zero for a month outside the calendar
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: len = 5'd31;
            M_APR, M_JUN, M_SEP, M_NOV:                      len = 5'd30;
            M_FEB:                                           len = leap ? 5'd29 : 5'd28;
            default:                                         len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ sv/gdad_if.sv @@
// Valid/ready channel interfaces for date requests and results.
interface gdad_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [15:0] days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                    output ready);
endinterface

interface gdad_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [1:0]  status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

@@ sv/gdad_walk_core.sv @@
// Sequencer and shared subtractor: year remainder, date check and month-by-month walk.
module gdad_walk_core
    import gdad_pkg::*;
#(
    parameter int DAYS_WIDTH = DAYS_WIDTH_DEF,
    parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctl    i_ctl,
    input  t_req    i_req,
    output t_sts    o_sts,
    output t_result o_result
);

    localparam int AW = (DAYS_WIDTH > 10) ? DAYS_WIDTH : 10;

    // Reciprocal of 400, exact for floor(y / 400) over the whole year range
    localparam int              QK   = YEAR_WIDTH + 9;
    localparam int              QMW  = QK - 8;
    localparam longint unsigned QM   = ((64'd1 << QK) + 64'(CYCLE_YEARS) - 64'd1) /
                                       64'(CYCLE_YEARS);
    localparam logic [QMW-1:0]  QMUL = QMW'(QM);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QUOT  = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [YEAR_WIDTH-1:0] r_y, n_y;
    logic [3:0]            r_m, n_m;
    logic [4:0]            r_d, n_d;
    logic [DAYS_WIDTH-1:0] r_n, n_n;
    logic [4:0]            r_rem, n_rem;
    logic [8:0]            r_r400, n_r400;
    logic [8:0]            r_q, n_q;
    logic [1:0]            r_st, n_st;

    // Shared subtract/compare unit
    logic [AW-1:0] alu_a, alu_b;
    logic [AW:0]   alu_diff;
    logic          alu_borrow;

    logic [YEAR_WIDTH+QMW-1:0] q_prod;
    logic [8:0]                q400;
    logic [4:0]                len;
    logic [8:0]                r400_inc;
    logic                      year_last;

    assign q_prod    = (YEAR_WIDTH+QMW)'(r_y) * (YEAR_WIDTH+QMW)'(QMUL);
    // Low nine bits of quotient * 400 (256 + 128 + 16)
    assign q400      = {r_q[0], 8'd0} + {r_q[1:0], 7'd0} + {r_q[4:0], 4'd0};
    assign len       = month_days(r_m, is_leap(r_r400));
    assign r400_inc  = (r_r400 == CYCLE_LAST) ? 9'd0 : r_r400 + 9'd1;
    assign year_last = (r_y == {YEAR_WIDTH{1'b1}});

    always_comb begin
        if (r_state == S_REM) begin
            alu_a = AW'(r_y[8:0]);
            alu_b = AW'(q400);
        end else begin
            alu_a = AW'(r_n);
            alu_b = AW'(r_rem);
        end
        alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
        alu_borrow = alu_diff[AW];
    end

    always_comb begin
        n_state = r_state;
        n_y     = r_y;
        n_m     = r_m;
        n_d     = r_d;
        n_n     = r_n;
        n_rem   = r_rem;
        n_r400  = r_r400;
        n_q     = r_q;
        n_st    = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_y     = YEAR_WIDTH'(i_req.start_year);
                    n_m     = i_req.start_month;
                    n_d     = i_req.start_day;
                    n_n     = DAYS_WIDTH'(i_req.days_to_add);
                    n_st    = ST_OK;
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                n_q     = 9'(q_prod >> QK);
                n_state = S_REM;
            end
            S_REM: begin
                // Remainder is below 400, so the low nine bits of the difference hold it
                n_r400  = alu_diff[8:0];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((len == 5'd0) || (r_d == 5'd0) || (r_d > len)) begin
                    n_y     = '0;
                    n_m     = '0;
                    n_d     = '0;
                    n_st    = ST_BAD_DATE;
                    n_state = S_DONE;
                end else begin
                    n_rem   = len - r_d;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!alu_borrow && (alu_diff[AW-1:0] != '0)) begin
                    // Remaining days run past this month: advance a month
                    n_n = alu_diff[DAYS_WIDTH-1:0];
                    n_d = 5'd0;
                    if (r_m == M_DEC) begin
                        if (year_last) begin
                            n_m     = M_DEC;
                            n_d     = DAY_LAST;
                            n_st    = ST_OVERFLOW;
                            n_state = S_DONE;
                        end else begin
                            n_y    = r_y + YEAR_WIDTH'(1);
                            n_m    = M_JAN;
                            n_r400 = r400_inc;
                            n_rem  = month_days(M_JAN, 1'b0);
                        end
                    end else begin
                        n_m   = r_m + 4'd1;
                        n_rem = month_days(r_m + 4'd1, is_leap(r_r400));
                    end
                end else begin
                    n_d     = r_d + r_n[4:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_y    <= n_y;
        r_m    <= n_m;
        r_d    <= n_d;
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_r400 <= n_r400;
        r_q    <= n_q;
        r_st   <= n_st;
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

    assign o_result.result_year  = 16'(r_y);
    assign o_result.result_month = r_m;
    assign o_result.result_day   = r_d;
    assign o_result.status       = r_st;

endmodule

@@ sv/gregorian_date_add_days_unit.sv @@
// Top level: request/result channels around the date walk core, with an output register.
//
// Use: present a start date (year, month, day) and a day count on i_req; the
// block returns the date that many days later on o_rsp with a status word:
// ok, bad start date (result fields zero) or year overflow (result pinned to
// 31 December of the last representable year).
// i_req.ready is high only while the core is idle, so one word is in work at
// a time. A request reduces the year modulo 400 (a reciprocal multiply, then
// a subtract through the shared subtractor), checks the date, walks the months
// with a step for each month crossed and a closing step, and hands over to the
// output register; the next word is taken once the core is back in idle. A
// bad start date returns without the month walk. The month walk sets the rate.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the finished core holds its result until the
// register frees, and o_rsp.valid stays high with a steady payload.
// Synchronous active-low reset returns the core to idle and drops o_rsp.valid.
module gregorian_date_add_days_unit
    import gdad_pkg::*;
#(
    parameter int DAYS_WIDTH = DAYS_WIDTH_DEF,
    parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdad_req_if.sink   i_req,
    gdad_rsp_if.source o_rsp
);

    t_ctl    ctl;
    t_sts    sts;
    t_req    req;
    t_result core_result;

    logic    r_out_valid, n_out_valid;
    t_result r_out;

    assign req.start_year  = i_req.start_year;
    assign req.start_month = i_req.start_month;
    assign req.start_day   = i_req.start_day;
    assign req.days_to_add = i_req.days_to_add;

    assign i_req.ready = sts.idle;
    assign ctl.start   = i_req.valid && sts.idle;
    // Move the finished word across once the output register is free
    assign ctl.take    = sts.done && (!r_out_valid || o_rsp.ready);

    gdad_walk_core #(
        .DAYS_WIDTH (DAYS_WIDTH),
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_req    (req),
        .o_sts    (sts),
        .o_result (core_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctl.take) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (ctl.take) begin
            r_out <= core_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_year  = r_out.result_year;
    assign o_rsp.result_month = r_out.result_month;
    assign o_rsp.result_day   = r_out.result_day;
    assign o_rsp.status       = r_out.status;

endmodule

@@ sv/gdad_checker.sv @@
// Port-level checker for the date-plus-days block, bound to the top level.
module gdad_checker
    import gdad_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [3:0]  i_rsp_month,
    input logic [4:0]  i_rsp_day,
    input logic [15:0] i_rsp_year,
    input logic [1:0]  i_rsp_status
);

    // A result word stays offered until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result word dropped while stalled");

    // One request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // A good result has a month from January to December and a non-zero day
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_OK) |->
            (i_rsp_month != 4'd0) && (i_rsp_month <= M_DEC) && (i_rsp_day != 5'd0))
        else $error("ok result is not a date");

    // A bad start date returns zeros, and no other status code appears
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            ((i_rsp_status == ST_OK) || (i_rsp_status == ST_OVERFLOW) ||
             ((i_rsp_status == ST_BAD_DATE) && (i_rsp_year == 16'd0) &&
              (i_rsp_month == 4'd0) && (i_rsp_day == 5'd0))))
        else $error("bad status with non-zero date or unknown status");

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_month  (o_rsp.result_month),
    .i_rsp_day    (o_rsp.result_day),
    .i_rsp_year   (o_rsp.result_year),
    .i_rsp_status (o_rsp.status)
);
